[rtl/apm_pkg.sv]
package apm_pkg;

	// fixed field widths
	localparam int OUT_W     = 24;
	localparam int COUNT_W   = 32;
	localparam int COEFF_W   = 32;
	localparam int MUL_B_W   = 33;

	// defaults for the top level parameters
	localparam int MAX_BLOCK_DEF   = 4096;
	localparam int SAMPLE_BITS_DEF = 24;
	localparam int QUEUE_DEPTH     = 2;

	localparam logic [COEFF_W-1:0] DECAY_RESET = 32'd4294669052;
	localparam logic [MUL_B_W-1:0] ONE_Q32     = 33'h1_0000_0000;

	// operation codes carried on tuser
	localparam logic OP_SAMPLE  = 1'b0;
	localparam logic OP_SILENCE = 1'b1;

	// back end sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_POW,
		ST_POW_ACC,
		ST_POW_SQR,
		ST_DIV,
		ST_PEAK,
		ST_MS_A,
		ST_MS_B,
		ST_SQRT,
		ST_EMIT
	} apm_state_t;

endpackage

[rtl/audio_peak_rms_meter.sv]
// Block audio level meter. Signed samples stream in through s_axis at one
// transfer per cycle; a block closes on tlast or after MAX_BLOCK samples, and
// a tuser-marked silence item decays the meter over tdata's silence count.
// Each closed block and each nonzero silence run yields one m_axis transfer
// with the decayed peak and the square root of the smoothed mean square.
// Block-end math runs in a shared sequencer behind a two-entry job queue:
// decay^n by square-and-multiply on a pipelined multiplier, then for a
// sample block a bit-serial divide, three multiplies and a square root of
// one digit per cycle; a silence run skips the divide and one multiply.
// Samples keep streaming during that time; s_axis only stalls when two jobs
// are already queued. The user must write decay_factor through cfg only
// while the meter is idle; the block itself does not enforce it.
module audio_peak_rms_meter #(
	parameter int MAX_BLOCK   = apm_pkg::MAX_BLOCK_DEF,
	parameter int SAMPLE_BITS = apm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// register write
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [apm_pkg::COEFF_W-1:0]           cfg_data,
	// input stream
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// sample, silence_count, zero pad
	input  logic [((SAMPLE_BITS + 32 + 7) / 8) * 8 - 1:0] s_axis_tdata,
	// operation
	input  logic                                  s_axis_tuser,
	// block_last
	input  logic                                  s_axis_tlast,
	// result stream
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// peak_level, rms_level
	output logic [2 * apm_pkg::OUT_W - 1:0]       m_axis_tdata
);
	import apm_pkg::*;

	localparam int CNT_W = $clog2(MAX_BLOCK + 1);
	localparam int SUM_W = 2 * SAMPLE_BITS - 1 + $clog2(MAX_BLOCK);
	localparam int JOB_W = 1 + COUNT_W + SUM_W + SAMPLE_BITS;

	logic [COEFF_W-1:0] decay_q;
	logic               job_push;
	logic [JOB_W-1:0]   job_wdata;
	logic               job_full;
	logic               job_pop;
	logic [JOB_W-1:0]   job_rdata;
	logic               job_empty;
	logic [OUT_W-1:0]   peak_level;
	logic [OUT_W-1:0]   rms_level;

	// decay coefficient register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_q <= DECAY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			decay_q <= cfg_data;
		end
	end

	apm_front #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.MAX_BLOCK   (MAX_BLOCK),
		.CNT_W       (CNT_W),
		.SUM_W       (SUM_W),
		.JOB_W       (JOB_W)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_axis_tvalid),
		.in_ready      (s_axis_tready),
		.operation     (s_axis_tuser),
		.sample        (s_axis_tdata[SAMPLE_BITS-1:0]),
		.block_last    (s_axis_tlast),
		.silence_count (s_axis_tdata[SAMPLE_BITS +: COUNT_W]),
		.job_push      (job_push),
		.job_data      (job_wdata),
		.job_full      (job_full)
	);

	apm_fifo #(
		.WIDTH (JOB_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.wdata  (job_wdata),
		.full   (job_full),
		.pop    (job_pop),
		.rdata  (job_rdata),
		.empty  (job_empty)
	);

	apm_back #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.MAX_BLOCK   (MAX_BLOCK),
		.CNT_W       (CNT_W),
		.SUM_W       (SUM_W),
		.JOB_W       (JOB_W)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.decay_factor (decay_q),
		.job_empty    (job_empty),
		.job_data     (job_rdata),
		.job_pop      (job_pop),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.peak_level   (peak_level),
		.rms_level    (rms_level)
	);

	assign m_axis_tdata = {rms_level, peak_level};

endmodule

[rtl/apm_front.sv]
module apm_front #(
	parameter int SAMPLE_BITS = apm_pkg::SAMPLE_BITS_DEF,
	parameter int MAX_BLOCK   = apm_pkg::MAX_BLOCK_DEF,
	parameter int CNT_W       = $clog2(MAX_BLOCK + 1),
	parameter int SUM_W       = 2 * SAMPLE_BITS - 1 + $clog2(MAX_BLOCK),
	parameter int JOB_W       = 1 + apm_pkg::COUNT_W + SUM_W + SAMPLE_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            operation,
	input  logic signed [SAMPLE_BITS-1:0]   sample,
	input  logic                            block_last,
	input  logic [apm_pkg::COUNT_W-1:0]     silence_count,
	output logic                            job_push,
	output logic [JOB_W-1:0]                job_data,
	input  logic                            job_full
);
	import apm_pkg::*;

	localparam int SQ_W = 2 * SAMPLE_BITS - 1;

	logic [SAMPLE_BITS-1:0] max_q;
	logic [SUM_W-1:0]       sum_q;
	logic [CNT_W-1:0]       cnt_q;

	logic                   accept;
	logic [SAMPLE_BITS-1:0] mag;
	logic [SQ_W-1:0]        sq;
	logic [SUM_W:0]         sum_add;
	logic [SUM_W-1:0]       sum_nxt;
	logic [SAMPLE_BITS-1:0] max_nxt;
	logic [CNT_W-1:0]       cnt_nxt;
	logic                   close;
	logic                   is_sil;

	assign in_ready = !job_full;
	assign accept   = in_valid && in_ready;
	assign is_sil   = (operation == OP_SILENCE);

	// magnitude, square and running sums of the open block
	always_comb begin
		mag     = sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample) : SAMPLE_BITS'(sample);
		sq      = SQ_W'(mag * mag);
		sum_add = (SUM_W + 1)'(sum_q) + (SUM_W + 1)'(sq);
		sum_nxt = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
		max_nxt = (mag > max_q) ? mag : max_q;
		cnt_nxt = cnt_q + CNT_W'(1);
		close   = block_last || (cnt_nxt == CNT_W'(MAX_BLOCK));
	end

	// queue a job on block close or on a nonzero silence run
	always_comb begin
		job_push = 1'b0;
		job_data = {max_nxt, sum_nxt, COUNT_W'(cnt_nxt), OP_SAMPLE};
		if (accept) begin
			if (is_sil) begin
				job_push = (silence_count != '0);
				job_data = {{SAMPLE_BITS{1'b0}}, {SUM_W{1'b0}}, silence_count, OP_SILENCE};
			end else begin
				job_push = close;
			end
		end
	end

	// block accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= '0;
			sum_q <= '0;
			cnt_q <= '0;
		end else if (accept && !is_sil) begin
			if (close) begin
				max_q <= '0;
				sum_q <= '0;
				cnt_q <= '0;
			end else begin
				max_q <= max_nxt;
				sum_q <= sum_nxt;
				cnt_q <= cnt_nxt;
			end
		end
	end

endmodule

[rtl/apm_fifo.sv]
module apm_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = apm_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FILL_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]  mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_q;
	logic [PTR_W-1:0]  rd_q;
	logic [FILL_W-1:0] fill_q;

	assign full  = (fill_q == FILL_W'(DEPTH));
	assign empty = (fill_q == '0);
	assign rdata = mem_q[rd_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_q] <= wdata;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push && !full) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop && !empty) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			fill_q <= fill_q + FILL_W'(push && !full) - FILL_W'(pop && !empty);
		end
	end

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |=> !(fill_q == '0))
		else $error("queue emptied without a pop");
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !push) |=> (fill_q == $past(fill_q) - FILL_W'(1)))
		else $error("queue fill level wrong after pop");
`endif

endmodule

[rtl/apm_mul.sv]
module apm_mul #(
	parameter int A_W = 47
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [A_W-1:0]                a,
	input  logic [apm_pkg::MUL_B_W-1:0]   b,
	output logic                          done,
	output logic [A_W:0]                  p
);
	import apm_pkg::*;

	localparam int HI_W = A_W - 32;
	localparam int LO_W = 32 + MUL_B_W;

	logic [LO_W-1:0]    lo_s1;
	logic [HI_W-1:0]    hi_s1;
	logic [MUL_B_W-1:0] b_s1;
	logic               v_s1;
	logic [A_W:0]       p_s2;
	logic               v_s2;

	// stage 1: low half product
	always_ff @(posedge clk) begin
		lo_s1 <= LO_W'(a[31:0]) * LO_W'(b);
		hi_s1 <= a[A_W-1:32];
		b_s1  <= b;
	end

	// stage 2: high half product plus carried low part, (a*b)>>32
	always_ff @(posedge clk) begin
		p_s2 <= (A_W + 1)'((A_W + 1)'(hi_s1) * (A_W + 1)'(b_s1)) + (A_W + 1)'(lo_s1 >> 32);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
		end
	end

	assign done = v_s2;
	assign p    = p_s2;

endmodule

[rtl/apm_back.sv]
module apm_back #(
	parameter int SAMPLE_BITS = apm_pkg::SAMPLE_BITS_DEF,
	parameter int MAX_BLOCK   = apm_pkg::MAX_BLOCK_DEF,
	parameter int CNT_W       = $clog2(MAX_BLOCK + 1),
	parameter int SUM_W       = 2 * SAMPLE_BITS - 1 + $clog2(MAX_BLOCK),
	parameter int JOB_W       = 1 + apm_pkg::COUNT_W + SUM_W + SAMPLE_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [apm_pkg::COEFF_W-1:0]  decay_factor,
	input  logic                         job_empty,
	input  logic [JOB_W-1:0]             job_data,
	output logic                         job_pop,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [apm_pkg::OUT_W-1:0]    peak_level,
	output logic [apm_pkg::OUT_W-1:0]    rms_level
);
	import apm_pkg::*;

	localparam int MS_W   = 2 * SAMPLE_BITS - 1;
	localparam int A_W    = (MS_W > 32) ? MS_W : 33;
	localparam int RAD_W  = MS_W + (MS_W % 2);
	localparam int H_W    = RAD_W / 2;
	localparam int DC_W   = $clog2(SUM_W + 1);
	localparam int SC_W   = $clog2(H_W + 1);

	apm_state_t state_q, state_nxt;

	// job fields
	logic                   j_sil;
	logic [COUNT_W-1:0]     j_n;
	logic [SUM_W-1:0]       j_sum;
	logic [SAMPLE_BITS-1:0] j_max;

	// sequencer registers
	logic                   is_sil_q;
	logic [CNT_W-1:0]       n_q;
	logic [SAMPLE_BITS-1:0] max_q;
	logic [COEFF_W-1:0]     acc_q;
	logic                   acc_one_q;
	logic [COEFF_W-1:0]     base_q;
	logic [COUNT_W-1:0]     e_q;
	logic [SAMPLE_BITS-1:0] peak_q;
	logic [MS_W-1:0]        ms_q;
	logic [MS_W-1:0]        t1_q;
	logic [SUM_W-1:0]       quo_q;
	logic [CNT_W-1:0]       rem_q;
	logic [DC_W-1:0]        div_cnt_q;
	logic [RAD_W-1:0]       sqx_q;
	logic [H_W+1:0]         sqrem_q;
	logic [H_W-1:0]         root_q;
	logic [SC_W-1:0]        sq_cnt_q;
	logic                   mul_wait_q;
	logic                   out_valid_q;
	logic [OUT_W-1:0]       peak_out_q;
	logic [OUT_W-1:0]       rms_out_q;

	// multiplier hookup
	logic                   mul_start;
	logic [A_W-1:0]         mul_a;
	logic [MUL_B_W-1:0]     mul_b;
	logic                   mul_done;
	logic [A_W:0]           mul_p;

	// step logic
	logic [CNT_W:0]         div_sh;
	logic                   div_bit;
	logic [H_W+3:0]         sq_sh;
	logic [H_W+3:0]         sq_trial;
	logic                   sq_ge;
	logic [SAMPLE_BITS-1:0] decayed;
	logic [MS_W-1:0]        ms_sum;
	logic                   emit_ok;

	assign {j_max, j_sum, j_n, j_sil} = job_data;

	apm_mul #(.A_W(A_W)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.p      (mul_p)
	);

	// one divider bit and one root digit per cycle
	always_comb begin
		div_sh   = {rem_q, quo_q[SUM_W-1]};
		div_bit  = (div_sh >= (CNT_W + 1)'(n_q));
		sq_sh    = {sqrem_q, sqx_q[RAD_W-1 -: 2]};
		sq_trial = (H_W + 4)'({root_q, 2'b01});
		sq_ge    = (sq_sh >= sq_trial);
		decayed  = SAMPLE_BITS'(mul_p);
		ms_sum   = t1_q + MS_W'(mul_p);
		emit_ok  = !out_valid_q || out_ready;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state, multiplier requests and operand select
	always_comb begin
		state_nxt = state_q;
		mul_start = 1'b0;
		mul_a     = A_W'(acc_q);
		mul_b     = MUL_B_W'(base_q);
		job_pop   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (!job_empty) begin
					job_pop   = 1'b1;
					state_nxt = ST_POW;
				end
			end
			ST_POW: begin
				if (e_q == '0) begin
					state_nxt = is_sil_q ? ST_PEAK : ST_DIV;
				end else if (e_q[0]) begin
					state_nxt = ST_POW_ACC;
				end else begin
					state_nxt = ST_POW_SQR;
				end
			end
			ST_POW_ACC: begin
				mul_start = !acc_one_q && !mul_wait_q;
				if (acc_one_q || mul_done) begin
					state_nxt = ST_POW_SQR;
				end
			end
			ST_POW_SQR: begin
				mul_a     = A_W'(base_q);
				mul_start = (e_q[COUNT_W-1:1] != '0) && !mul_wait_q;
				if ((e_q[COUNT_W-1:1] == '0) || mul_done) begin
					state_nxt = ST_POW;
				end
			end
			ST_DIV: begin
				if (div_cnt_q == DC_W'(1)) begin
					state_nxt = ST_PEAK;
				end
			end
			ST_PEAK: begin
				mul_a     = A_W'(peak_q);
				mul_b     = MUL_B_W'(acc_q);
				mul_start = !mul_wait_q;
				if (mul_done) begin
					state_nxt = is_sil_q ? ST_MS_B : ST_MS_A;
				end
			end
			ST_MS_A: begin
				mul_a     = A_W'(quo_q);
				mul_b     = ONE_Q32 - MUL_B_W'(acc_q);
				mul_start = !mul_wait_q;
				if (mul_done) begin
					state_nxt = ST_MS_B;
				end
			end
			ST_MS_B: begin
				mul_a     = A_W'(ms_q);
				mul_b     = MUL_B_W'(acc_q);
				mul_start = !mul_wait_q;
				if (mul_done) begin
					state_nxt = ST_SQRT;
				end
			end
			ST_SQRT: begin
				if (sq_cnt_q == SC_W'(1)) begin
					state_nxt = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (emit_ok) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// multiplier handshake and meter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_wait_q  <= 1'b0;
			peak_q      <= '0;
			ms_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (mul_start) begin
				mul_wait_q <= 1'b1;
			end else if (mul_done) begin
				mul_wait_q <= 1'b0;
			end
			if (state_q == ST_PEAK && mul_done) begin
				peak_q <= (max_q > decayed) ? max_q : decayed;
			end
			if (state_q == ST_MS_B && mul_done) begin
				ms_q <= ms_sum;
			end
			if (state_q == ST_EMIT && emit_ok) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath work registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				is_sil_q  <= j_sil;
				n_q       <= CNT_W'(j_n);
				max_q     <= j_max;
				e_q       <= j_n;
				base_q    <= decay_factor;
				acc_q     <= decay_factor;
				acc_one_q <= 1'b1;
				quo_q     <= j_sum;
				rem_q     <= '0;
				div_cnt_q <= DC_W'(SUM_W);
				t1_q      <= '0;
			end
			ST_POW_ACC: begin
				if (acc_one_q) begin
					acc_q     <= base_q;
					acc_one_q <= 1'b0;
				end else if (mul_done) begin
					acc_q <= COEFF_W'(mul_p);
				end
			end
			ST_POW_SQR: begin
				if (e_q[COUNT_W-1:1] == '0) begin
					e_q <= '0;
				end else if (mul_done) begin
					base_q <= COEFF_W'(mul_p);
					e_q    <= e_q >> 1;
				end
			end
			ST_DIV: begin
				rem_q     <= div_bit ? CNT_W'(div_sh - (CNT_W + 1)'(n_q)) : CNT_W'(div_sh);
				quo_q     <= {quo_q[SUM_W-2:0], div_bit};
				div_cnt_q <= div_cnt_q - DC_W'(1);
			end
			ST_MS_A: begin
				if (mul_done) begin
					t1_q <= MS_W'(mul_p);
				end
			end
			ST_MS_B: begin
				sqx_q    <= RAD_W'(ms_sum);
				sqrem_q  <= '0;
				root_q   <= '0;
				sq_cnt_q <= SC_W'(H_W);
			end
			ST_SQRT: begin
				sqx_q    <= sqx_q << 2;
				sqrem_q  <= sq_ge ? (H_W + 2)'(sq_sh - sq_trial) : (H_W + 2)'(sq_sh);
				root_q   <= {root_q[H_W-2:0], sq_ge};
				sq_cnt_q <= sq_cnt_q - SC_W'(1);
			end
			ST_EMIT: begin
				if (emit_ok) begin
					peak_out_q <= OUT_W'(peak_q);
					rms_out_q  <= OUT_W'(root_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid  = out_valid_q;
	assign peak_level = peak_out_q;
	assign rms_level  = rms_out_q;

`ifndef SYNTHESIS
	a_mul_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> mul_wait_q)
		else $error("multiplier result without a request");
	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (div_cnt_q != '0))
		else $error("divider ran past its last bit");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> (state_q == ST_IDLE && !job_empty))
		else $error("job taken while busy");
`endif

endmodule

[test/apm_checker.sv]
`timescale 1ns / 100ps
module apm_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [31:0] cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [55:0] s_tdata,
	input  logic        s_tuser,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,
	output int          errors,
	output int          pending,
	output int          levels_seen,
	output int          blocks_closed
);
	import apm_pkg::*;

	localparam int MAXB = MAX_BLOCK_DEF;

	typedef struct packed {
		logic [23:0] rms;
		logic [23:0] peak;
	} level_t;

	level_t      level_q[$];
	logic [31:0] coeff;
	logic [63:0] peak_v;
	logic [63:0] msq;
	logic [63:0] blk_max;
	logic [63:0] blk_sum;
	logic [31:0] blk_cnt;

	// truncated q0.32 product
	function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = a * b;
		return p[95:32];
	endfunction

	function automatic logic [63:0] qpow(input logic [31:0] base, input logic [31:0] n);
		logic [63:0] acc;
		logic [63:0] b;
		acc = 64'h1_0000_0000;
		b = base;
		while (n != 0) begin
			if (n[0])
				acc = qmul(acc, b);
			b = qmul(b, b);
			n = n >> 1;
		end
		return acc;
	endfunction

	function automatic logic [63:0] root_floor(input logic [63:0] x);
		logic [63:0] r;
		r = 0;
		for (int i = 31; i >= 0; i--)
			if ((r | (64'd1 << i)) * (r | (64'd1 << i)) <= x)
				r = r | (64'd1 << i);
		return r;
	endfunction

	function automatic level_t level_now();
		level_t l;
		l.peak = peak_v[23:0];
		l.rms = 24'(root_floor(msq));
		return l;
	endfunction

	// predict one input transfer
	task automatic meter_step(input logic op, input logic [23:0] smp, input logic last,
		input logic [31:0] cnt);
		logic [63:0] k;
		logic [63:0] mag;
		logic [63:0] sq;
		logic [63:0] dec;
		logic [63:0] mean;
		mag = smp[23] ? {40'd0, -smp} : {40'd0, smp};
		if (smp == 24'h800000)
			mag = 64'h800000;
		if (op == OP_SILENCE) begin
			if (cnt != 0) begin
				k = qpow(coeff, cnt);
				peak_v = qmul(peak_v, k);
				msq = qmul(msq, k);
				level_q.push_back(level_now());
			end
		end else begin
			sq = mag * mag;
			if (mag > blk_max)
				blk_max = mag;
			blk_sum += sq;
			blk_cnt++;
			if (last || blk_cnt >= MAXB) begin
				k = qpow(coeff, blk_cnt);
				mean = blk_sum / blk_cnt;
				dec = qmul(peak_v, k);
				peak_v = (blk_max > dec) ? blk_max : dec;
				msq = qmul(mean, 64'h1_0000_0000 - k) + qmul(msq, k);
				blk_max = 0;
				blk_sum = 0;
				blk_cnt = 0;
				blocks_closed++;
				level_q.push_back(level_now());
			end
		end
	endtask

	// watch all channels at the rising edge
	always @(posedge clk or negedge arst_n) begin
		level_t want;
		level_t got;
		if (!arst_n) begin
			coeff = DECAY_RESET;
			peak_v = 0;
			msq = 0;
			blk_max = 0;
			blk_sum = 0;
			blk_cnt = 0;
			errors = 0;
			levels_seen = 0;
			blocks_closed = 0;
			level_q.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				levels_seen++;
				if (level_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected level transfer peak=%0d rms=%0d",
							got.peak, got.rms);
				end else begin
					want = level_q.pop_front();
					if (want.peak != got.peak || want.rms != got.rms) begin
						errors++;
						if (errors <= 10)
							$display("level mismatch: want peak=%0d rms=%0d got peak=%0d rms=%0d",
								want.peak, want.rms, got.peak, got.rms);
					end
				end
			end
			if (s_tvalid && s_tready)
				meter_step(s_tuser, s_tdata[23:0], s_tlast, s_tdata[55:24]);
			if (cfg_valid && cfg_ready)
				coeff = cfg_data;
		end
		pending = level_q.size();
	end
endmodule

[test/tb_audio_peak_rms_meter.sv]
`timescale 1ns / 100ps
module tb_audio_peak_rms_meter;
	import apm_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata;
	logic        s_axis_tuser;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;
	int          errors;
	int          pending;
	int          levels_seen;
	int          blocks_closed;
	int          send_idle;
	int          recv_idle;
	int          hold_cycles;
	int          cycles;
	int          items_sent;
	int          run_len;

	audio_peak_rms_meter dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	apm_checker chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready), .s_tdata(s_axis_tdata),
		.s_tuser(s_axis_tuser), .s_tlast(s_axis_tlast),
		.m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready), .m_tdata(m_axis_tdata),
		.errors(errors), .pending(pending), .levels_seen(levels_seen),
		.blocks_closed(blocks_closed)
	);

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// receiver with random stalls and long hold-offs
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 1500000) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// one input transfer, valid stays up into the next transfer unless idling
	task automatic send_item(input logic op, input logic [23:0] smp, input logic last,
		input logic [31:0] cnt);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tlast <= last;
		s_axis_tdata <= {cnt, smp};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (200)
			@(negedge clk);
	endtask

	task automatic write_coeff(input logic [31:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// mostly samples with short blocks, some silence runs
	task automatic random_items(input int n);
		logic [31:0] cnt;
		repeat (n) begin
			if ($urandom_range(9) == 0) begin
				case ($urandom_range(3))
					0: cnt = 0;
					1: cnt = $urandom;
					default: cnt = $urandom_range(300);
				endcase
				send_item(OP_SILENCE, 24'($urandom), 1'($urandom), cnt);
			end else begin
				run_len = run_len + 1;
				send_item(OP_SAMPLE, 24'($urandom),
					($urandom_range(15) == 0) || run_len > 40, $urandom);
				if (s_axis_tlast)
					run_len = 0;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = OP_SAMPLE;
		s_axis_tlast = 1'b0;
		m_axis_tready = 1'b0;
		hold_cycles = 0;
		cycles = 0;
		items_sent = 0;
		run_len = 0;
		send_idle = 0;
		recv_idle = 0;
		repeat (10)
			@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, zero silence, silence inside an open block
		send_item(OP_SAMPLE, 24'h7FFFFF, 1'b1, 32'd0);
		send_item(OP_SAMPLE, 24'h800000, 1'b0, 32'd0);
		send_item(OP_SILENCE, 24'h0, 1'b0, 32'd0);
		send_item(OP_SILENCE, 24'h0, 1'b0, 32'd5);
		send_item(OP_SAMPLE, 24'h000001, 1'b1, 32'hFFFFFFFF);
		send_item(OP_SILENCE, 24'hFFFFFF, 1'b1, 32'hFFFFFFFF);
		send_item(OP_SAMPLE, 24'h000000, 1'b1, 32'd0);
		send_item(OP_SILENCE, 24'h0, 1'b0, 32'd1);
		drain();
		write_coeff(32'hFFFFFFFF);
		send_item(OP_SAMPLE, 24'h400000, 1'b1, 32'd0);
		send_item(OP_SILENCE, 24'h0, 1'b0, 32'd1000);
		drain();
		write_coeff(32'd0);
		send_item(OP_SAMPLE, 24'hC00000, 1'b1, 32'd0);
		send_item(OP_SAMPLE, 24'h123456, 1'b0, 32'd0);
		send_item(OP_SAMPLE, 24'h654321, 1'b1, 32'd0);
		send_item(OP_SILENCE, 24'h0, 1'b0, 32'd3);
		drain();
		write_coeff(DECAY_RESET);

		// random phases with changing idle ratios
		send_idle = 16;
		recv_idle = 47;
		random_items(550);
		drain();
		write_coeff($urandom);
		send_idle = 47;
		recv_idle = 16;
		random_items(550);
		drain();
		write_coeff(32'hFFFF0000 | $urandom_range(65535));
		send_idle = 0;
		recv_idle = 0;
		hold_cycles = 3000;
		random_items(650);
		drain();

		$display("sent %0d items, closed %0d blocks, checked %0d level transfers",
			items_sent, blocks_closed, levels_seen);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
